// ===== sv/sacl_pkg.sv =====
// Shared constants, codes and helpers for the set-associative cache model.
`timescale 1ns / 1ps

package sacl_pkg;

  localparam int ADDR_W = 64;
  // Offset and set index are both at least one bit, so a tag never exceeds 62 bits.
  localparam int TAG_W  = 62;
  localparam int CNT_W  = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam int OFS_MAX    = 48;

  // Access kinds; the unused code behaves as a load.
  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_STORE  = 2'd1;
  localparam logic [1:0] REQ_MODIFY = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFS_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS     = 2'd2;

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_PROC  = 3'b100
  } state_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

// ===== sv/set_assoc_cache_lru_sim_top.sv =====
// Set-associative cache with LRU replacement: lookup, fill, aging and running totals.
`timescale 1ns / 1ps

//  channel | handshake                | payload
//  --------+--------------------------+------------------------------------------
//  in      | in_valid / in_stall      | req_type, address
//  out     | out_valid / out_stall    | was_hit, was_evicted, hit_total,
//          |                          | miss_total, evict_total
//  cfg     | cfg_write                | cfg_index, cfg_data
//
//  For each item the accept edge issues the set read; in ST_PROC the updated
//  set is written back and the result register loaded. A new item is taken
//  only after that write-back (read then write of one set row).
//  After reset a clearing pass walks all 2**MAX_SET_BITS rows, one per cycle,
//  with in_stall high; configuration writes are taken during it.
//  A stalled result holds the write-back until the result register frees.

module set_assoc_cache_lru_sim_top #(
  parameter int MAX_SET_BITS = 8,
  parameter int MAX_WAYS     = 8,
  parameter int AGE_WIDTH    = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_write,
  input  logic [sacl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sacl_pkg::CFG_DATA_W-1:0]   cfg_data,
  // requests
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [1:0]                        req_type,
  input  logic [sacl_pkg::ADDR_W-1:0]       address,
  // results
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              was_hit,
  output logic                              was_evicted,
  output logic [sacl_pkg::CNT_W-1:0]        hit_total,
  output logic [sacl_pkg::CNT_W-1:0]        miss_total,
  output logic [sacl_pkg::CNT_W-1:0]        evict_total
);

  localparam int TAG_W   = sacl_pkg::TAG_W;
  localparam int ROWS    = 1 << MAX_SET_BITS;
  localparam int TAG_LO  = MAX_WAYS;
  localparam int AGE_LO  = MAX_WAYS + MAX_WAYS * TAG_W;
  localparam int ROW_W   = MAX_WAYS * (1 + TAG_W + AGE_WIDTH);
  localparam int WAY_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCNT_W  = $clog2(MAX_WAYS + 1);
  localparam int SB_W    = $clog2(MAX_SET_BITS + 1);
  localparam int SH_W    = 7;

  // ---------------------------------------------------------------------------
  // Configuration registers, clamped where used
  // ---------------------------------------------------------------------------
  logic [3:0] set_index_bits;
  logic [5:0] offset_bits;
  logic [3:0] ways_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_index_bits <= 4'd1;
      offset_bits    <= 6'd1;
      ways_in_use    <= 4'd1;
    end else if (cfg_write) begin
      case (cfg_index)
        sacl_pkg::CFG_SET_BITS: set_index_bits <= cfg_data[3:0];
        sacl_pkg::CFG_OFS_BITS: offset_bits    <= cfg_data;
        sacl_pkg::CFG_WAYS:     ways_in_use    <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  logic [SB_W-1:0]   sbits;
  logic [5:0]        obits;
  logic [WCNT_W-1:0] ways;

  always_comb begin
    if (set_index_bits == 4'd0)                  sbits = SB_W'(1);
    else if (32'(set_index_bits) > MAX_SET_BITS) sbits = SB_W'(MAX_SET_BITS);
    else                                         sbits = SB_W'(set_index_bits);

    if (offset_bits == 6'd0)                        obits = 6'd1;
    else if (32'(offset_bits) > sacl_pkg::OFS_MAX)  obits = 6'(sacl_pkg::OFS_MAX);
    else                                            obits = offset_bits;

    if (ways_in_use == 4'd0)                 ways = WCNT_W'(1);
    else if (32'(ways_in_use) > MAX_WAYS)    ways = WCNT_W'(MAX_WAYS);
    else                                     ways = WCNT_W'(ways_in_use);
  end

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  sacl_pkg::state_t state, state_next;
  logic [MAX_SET_BITS-1:0] clr_ptr;
  logic accept, done;

  assign in_stall = (state != sacl_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  // Finish only when the result register is free or drains this cycle.
  assign done     = (state == sacl_pkg::ST_PROC) && (!out_valid || !out_stall);

  always_comb begin
    state_next = state;
    case (state)
      sacl_pkg::ST_CLEAR: if (clr_ptr == {MAX_SET_BITS{1'b1}}) state_next = sacl_pkg::ST_IDLE;
      sacl_pkg::ST_IDLE:  if (accept) state_next = sacl_pkg::ST_PROC;
      sacl_pkg::ST_PROC:  if (done) state_next = sacl_pkg::ST_IDLE;
      default:            state_next = sacl_pkg::ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= sacl_pkg::ST_CLEAR;
      clr_ptr <= '0;
    end else begin
      state <= state_next;
      if (state == sacl_pkg::ST_CLEAR) clr_ptr <= clr_ptr + 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Address split at accept time
  // ---------------------------------------------------------------------------
  logic [MAX_SET_BITS-1:0]     set_mask, in_set;
  logic [sacl_pkg::ADDR_W-1:0] set_shift, tag_shift;
  logic [SH_W-1:0]             tag_amt;

  always_comb begin
    for (int i = 0; i < MAX_SET_BITS; i++) begin
      set_mask[i] = (SB_W'(i) < sbits);
    end
    set_shift = address >> obits;
    in_set    = set_shift[MAX_SET_BITS-1:0] & set_mask;
    tag_amt   = SH_W'(obits) + SH_W'(sbits);
    tag_shift = address >> tag_amt;
  end

  // Hold the request across the read.
  logic [1:0]              req_kind;
  logic [TAG_W-1:0]        req_tag;
  logic [MAX_SET_BITS-1:0] req_set;

  always_ff @(posedge clk) begin
    if (accept) begin
      req_kind <= req_type;
      req_tag  <= tag_shift[TAG_W-1:0];
      req_set  <= in_set;
    end
  end

  // ---------------------------------------------------------------------------
  // Set memory: one row holds valid bits, tags and ages of all ways
  // ---------------------------------------------------------------------------
  logic [ROW_W-1:0]        mem [ROWS];
  logic [ROW_W-1:0]        rdata, wdata, mem_wdata;
  logic                    mem_we;
  logic [MAX_SET_BITS-1:0] mem_waddr;

  assign mem_we    = (state == sacl_pkg::ST_CLEAR) || done;
  assign mem_waddr = (state == sacl_pkg::ST_CLEAR) ? clr_ptr : req_set;
  // Clearing writes zero valid bits; tags and ages of invalid lines are never used.
  assign mem_wdata = (state == sacl_pkg::ST_CLEAR) ? '0 : wdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (accept) rdata <= mem[in_set];
  end

  // ---------------------------------------------------------------------------
  // Lookup, victim choice and aging on the read row
  // ---------------------------------------------------------------------------
  logic [MAX_WAYS-1:0]  v_old, in_use, hit_vec, free_vec;
  logic                 hit, any_free, evict;
  logic [WAY_W-1:0]     hit_way, free_way, max_way, sel_way;
  logic [AGE_WIDTH-1:0] best_age;

  always_comb begin
    v_old    = rdata[MAX_WAYS-1:0];
    hit      = 1'b0;
    any_free = 1'b0;
    hit_way  = '0;
    free_way = '0;
    max_way  = '0;
    best_age = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_use[w]   = (WCNT_W'(w) < ways);
      hit_vec[w]  = in_use[w] && v_old[w] &&
                    (rdata[TAG_LO + w*TAG_W +: TAG_W] == req_tag);
      free_vec[w] = in_use[w] && !v_old[w];
    end
    // Scan downward so the lowest matching and lowest free way win.
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (free_vec[w]) begin
        any_free = 1'b1;
        free_way = WAY_W'(w);
      end
    end
    // Oldest line, ties to the higher way.
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (in_use[w] && (rdata[AGE_LO + w*AGE_WIDTH +: AGE_WIDTH] >= best_age)) begin
        max_way  = WAY_W'(w);
        best_age = rdata[AGE_LO + w*AGE_WIDTH +: AGE_WIDTH];
      end
    end
    evict   = !hit && !any_free;
    sel_way = hit ? hit_way : (any_free ? free_way : max_way);
  end

  always_comb begin
    logic                 nv;
    logic [AGE_WIDTH-1:0] na;
    wdata = rdata;
    for (int w = 0; w < MAX_WAYS; w++) begin
      nv = v_old[w];
      na = rdata[AGE_LO + w*AGE_WIDTH +: AGE_WIDTH];
      if (in_use[w] && (WAY_W'(w) == sel_way)) begin
        nv = 1'b1;
        na = '0;
        if (!hit) wdata[TAG_LO + w*TAG_W +: TAG_W] = req_tag;
      end
      // Age every valid line in use, saturating.
      if (in_use[w] && nv && (na != {AGE_WIDTH{1'b1}})) na = na + 1'b1;
      wdata[w] = nv;
      wdata[AGE_LO + w*AGE_WIDTH +: AGE_WIDTH] = na;
    end
  end

  // ---------------------------------------------------------------------------
  // Totals and result register
  // ---------------------------------------------------------------------------
  logic [sacl_pkg::CNT_W-1:0] hit_count, miss_count, evict_count;
  logic [sacl_pkg::CNT_W-1:0] hit_step, hit_next, miss_next, evict_next;

  always_comb begin
    hit_step   = hit ? sacl_pkg::sat_inc(hit_count) : hit_count;
    // A modify counts one extra hit.
    hit_next   = (req_kind == sacl_pkg::REQ_MODIFY) ? sacl_pkg::sat_inc(hit_step) : hit_step;
    miss_next  = hit ? miss_count : sacl_pkg::sat_inc(miss_count);
    evict_next = evict ? sacl_pkg::sat_inc(evict_count) : evict_count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_count   <= '0;
      miss_count  <= '0;
      evict_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (done) begin
        hit_count   <= hit_next;
        miss_count  <= miss_next;
        evict_count <= evict_next;
        out_valid   <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      was_hit     <= hit;
      was_evicted <= evict;
      hit_total   <= hit_next;
      miss_total  <= miss_next;
      evict_total <= evict_next;
    end
  end

endmodule

// ===== dv/tb_set_assoc_cache_lru_sim_top.sv =====
// Self-checking testbench for the LRU set-associative cache: directed and random accesses.
`timescale 1ns / 1ps

module tb_set_assoc_cache_lru_sim_top;

  // Same sizes the block is built with below.
  localparam int SET_BITS_MAX = 8;
  localparam int WAY_MAX      = 8;
  localparam int AGE_BITS     = 32;
  localparam int LINE_COUNT   = (1 << SET_BITS_MAX) * WAY_MAX;

  localparam logic [AGE_BITS-1:0]        AGE_TOP   = '1;
  localparam logic [sacl_pkg::CNT_W-1:0] COUNT_TOP = '1;

  // The unused request code; the block must treat it as a load.
  localparam logic [1:0] REQ_SPARE = 2'd3;

  // Per-result compare bundle.
  typedef struct packed {
    logic                       hit;
    logic                       evict;
    logic [sacl_pkg::CNT_W-1:0] hits;
    logic [sacl_pkg::CNT_W-1:0] misses;
    logic [sacl_pkg::CNT_W-1:0] evicts;
  } access_result_t;

  logic                            clk;
  logic                            rst;
  logic                            cfg_write;
  logic [sacl_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [sacl_pkg::CFG_DATA_W-1:0] cfg_data;
  logic                            in_valid;
  logic                            in_stall;
  logic [1:0]                      req_type;
  logic [sacl_pkg::ADDR_W-1:0]     address;
  logic                            out_valid;
  logic                            out_stall;
  logic                            was_hit;
  logic                            was_evicted;
  logic [sacl_pkg::CNT_W-1:0]      hit_total;
  logic [sacl_pkg::CNT_W-1:0]      miss_total;
  logic [sacl_pkg::CNT_W-1:0]      evict_total;

  // Shadow copy of the cache contents, the totals and the registers.
  logic                       cached_valid [LINE_COUNT];
  logic [sacl_pkg::TAG_W-1:0] cached_tag   [LINE_COUNT];
  logic [AGE_BITS-1:0]        cached_age   [LINE_COUNT];
  logic [sacl_pkg::CNT_W-1:0] hit_cnt   = '0;
  logic [sacl_pkg::CNT_W-1:0] miss_cnt  = '0;
  logic [sacl_pkg::CNT_W-1:0] evict_cnt = '0;
  logic [3:0]                 reg_set_bits = 4'd1;
  logic [5:0]                 reg_ofs_bits = 6'd1;
  logic [3:0]                 reg_ways     = 4'd1;

  // Results predicted for accepted accesses, oldest first.
  access_result_t pending_results [$];

  int unsigned mismatches     = 0;
  int unsigned results_seen   = 0;
  // Idle controls for the sender and the stall generator.
  bit          tx_gaps_on     = 1'b1;
  bit          rx_gaps_on     = 1'b1;
  int unsigned rx_hold_cycles = 0;

  set_assoc_cache_lru_sim_top #(
    .MAX_SET_BITS(SET_BITS_MAX),
    .MAX_WAYS    (WAY_MAX),
    .AGE_WIDTH   (AGE_BITS)
  ) uut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .req_type   (req_type),
    .address    (address),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .was_hit    (was_hit),
    .was_evicted(was_evicted),
    .hit_total  (hit_total),
    .miss_total (miss_total),
    .evict_total(evict_total)
  );

  initial begin : clock_gen
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin : watchdog
    #6_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic int unsigned clamp_field(input int unsigned v, input int unsigned lo,
                                              input int unsigned hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // Out-of-range register values are clamped where they are used, not when written.
  function automatic int unsigned eff_set_bits();
    return clamp_field(32'(reg_set_bits), 1, SET_BITS_MAX);
  endfunction

  function automatic int unsigned eff_ofs_bits();
    return clamp_field(32'(reg_ofs_bits), 1, sacl_pkg::OFS_MAX);
  endfunction

  function automatic int unsigned eff_ways();
    return clamp_field(32'(reg_ways), 1, WAY_MAX);
  endfunction

  function automatic logic [sacl_pkg::CNT_W-1:0] count_up(
      input logic [sacl_pkg::CNT_W-1:0] v);
    return (v == COUNT_TOP) ? v : v + 1'b1;
  endfunction

  // Apply one access to the shadow cache and return what the block must report.
  function automatic access_result_t cache_access(input logic [1:0] kind,
                                                  input logic [sacl_pkg::ADDR_W-1:0] addr);
    int unsigned                 sb;
    int unsigned                 ob;
    int unsigned                 nw;
    int unsigned                 base;
    int unsigned                 victim;
    logic [sacl_pkg::ADDR_W-1:0] set_field;
    logic [sacl_pkg::TAG_W-1:0]  tag;
    logic [AGE_BITS-1:0]         oldest;
    logic                        hit;
    logic                        free_found;
    access_result_t              res;
    sb = eff_set_bits();
    ob = eff_ofs_bits();
    nw = eff_ways();
    set_field = (addr >> ob) & ((64'd1 << sb) - 64'd1);
    base = 32'(set_field) * WAY_MAX;
    // Offset plus index is at least two bits, so the tag always fits.
    tag = sacl_pkg::TAG_W'(addr >> (ob + sb));
    hit = 1'b0;
    free_found = 1'b0;
    victim = 0;
    oldest = '0;

    for (int w = 0; w < nw && !hit; w++) begin
      if (cached_valid[base + w] && cached_tag[base + w] == tag) begin
        hit = 1'b1;
        cached_age[base + w] = '0;
      end
    end

    if (hit) begin
      hit_cnt = count_up(hit_cnt);
    end else begin
      miss_cnt = count_up(miss_cnt);
      // Lowest free way wins; otherwise the oldest, ties going to the higher way.
      for (int w = 0; w < nw && !free_found; w++) begin
        if (!cached_valid[base + w]) begin
          victim = w;
          free_found = 1'b1;
        end else if (cached_age[base + w] >= oldest) begin
          victim = w;
          oldest = cached_age[base + w];
        end
      end
      if (!free_found) evict_cnt = count_up(evict_cnt);
      cached_valid[base + victim] = 1'b1;
      cached_tag[base + victim]   = tag;
      cached_age[base + victim]   = '0;
    end

    for (int w = 0; w < nw; w++) begin
      if (cached_valid[base + w] && cached_age[base + w] != AGE_TOP)
        cached_age[base + w] = cached_age[base + w] + 1'b1;
    end

    // A modify is a load followed by a store that always hits.
    if (kind == sacl_pkg::REQ_MODIFY) hit_cnt = count_up(hit_cnt);

    res.hit    = hit;
    res.evict  = !hit && !free_found;
    res.hits   = hit_cnt;
    res.misses = miss_cnt;
    res.evicts = evict_cnt;
    return res;
  endfunction

  // Build an address from tag, set and offset under the current settings.
  function automatic logic [sacl_pkg::ADDR_W-1:0] addr_of(
      input logic [sacl_pkg::ADDR_W-1:0] tag,
      input int unsigned set_no,
      input logic [sacl_pkg::ADDR_W-1:0] low);
    int unsigned                 sb;
    int unsigned                 ob;
    logic [sacl_pkg::ADDR_W-1:0] set_field;
    sb = eff_set_bits();
    ob = eff_ofs_bits();
    set_field = sacl_pkg::ADDR_W'(set_no);
    set_field = set_field & ((64'd1 << sb) - 64'd1);
    return (tag << (ob + sb)) | (set_field << ob) | (low & ((64'd1 << ob) - 64'd1));
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one access and hold it until taken. in_valid is left high on return,
  // so the caller must send again or drain before time advances.
  task automatic send_access(input logic [1:0] kind,
                             input logic [sacl_pkg::ADDR_W-1:0] addr);
    if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    address  <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_results.push_back(cache_access(kind, addr));
  endtask

  // Mostly accesses that revisit a few sets with a few tags more than there
  // are ways, so hits, fills and evictions all happen; some spread over every
  // set, and some fully random addresses to toggle every address bit.
  task automatic send_random_access();
    logic [1:0]                  kind;
    logic [sacl_pkg::ADDR_W-1:0] addr;
    kind = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0: addr = {$urandom, $urandom};
      1: addr = addr_of(64'($urandom_range(0, 2 * WAY_MAX)), $urandom, {$urandom, $urandom});
      default: addr = addr_of(64'($urandom_range(0, eff_ways() + 2)), $urandom_range(0, 3),
                              {$urandom, $urandom});
    endcase
    send_access(kind, addr);
  endtask

  // Drop in_valid and wait for every outstanding result.
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Write all three registers on back-to-back edges; only call while idle.
  task automatic write_regs(input logic [sacl_pkg::CFG_DATA_W-1:0] set_val,
                            input logic [sacl_pkg::CFG_DATA_W-1:0] ofs_val,
                            input logic [sacl_pkg::CFG_DATA_W-1:0] ways_val);
    cfg_write <= 1'b1;
    cfg_index <= sacl_pkg::CFG_SET_BITS;
    cfg_data  <= set_val;
    @(posedge clk);
    reg_set_bits = set_val[3:0];
    cfg_index <= sacl_pkg::CFG_OFS_BITS;
    cfg_data  <= ofs_val;
    @(posedge clk);
    reg_ofs_bits = ofs_val;
    cfg_index <= sacl_pkg::CFG_WAYS;
    cfg_data  <= ways_val;
    @(posedge clk);
    reg_ways = ways_val[3:0];
    cfg_write <= 1'b0;
  endtask

  // Result-side stall: a long hold-off when asked for, otherwise random bursts.
  initial begin : rx_stall_gen
    int unsigned burst;
    burst = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles != 0) begin
        rx_hold_cycles--;
        out_stall <= 1'b1;
      end else if (burst != 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (rx_gaps_on && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(0, 14);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch on result %0d: %s", $time, results_seen, msg);
  endtask

  // Compare every accepted result against the oldest prediction.
  initial begin : result_checker
    access_result_t want;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          report_mismatch("result with no access pending");
        end else begin
          want = pending_results.pop_front();
          if (was_hit !== want.hit)
            report_mismatch($sformatf("was_hit got %b want %b", was_hit, want.hit));
          if (was_evicted !== want.evict)
            report_mismatch($sformatf("was_evicted got %b want %b", was_evicted, want.evict));
          if (hit_total !== want.hits)
            report_mismatch($sformatf("hit_total got %0d want %0d", hit_total, want.hits));
          if (miss_total !== want.misses)
            report_mismatch($sformatf("miss_total got %0d want %0d", miss_total, want.misses));
          if (evict_total !== want.evicts)
            report_mismatch($sformatf("evict_total got %0d want %0d", evict_total, want.evicts));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings (one set bit, one offset bit, one way): miss, hit on the
  // offset bit alone, modify's extra hit, the spare code as a load, the
  // address extremes, and eviction in a direct-mapped set.
  task automatic test_reset_defaults();
    send_access(sacl_pkg::REQ_LOAD,   64'h0);
    send_access(sacl_pkg::REQ_LOAD,   64'h1);
    send_access(sacl_pkg::REQ_MODIFY, 64'h0);
    send_access(sacl_pkg::REQ_STORE,  64'hFFFF_FFFF_FFFF_FFFF);
    send_access(sacl_pkg::REQ_STORE,  64'h4);
    send_access(REQ_SPARE,            64'hFFFF_FFFF_FFFF_FFFF);
    send_access(sacl_pkg::REQ_LOAD,   64'h8000_0000_0000_0000);
  endtask

  // Ways left out of use keep their stale age; bringing them back creates an
  // age tie that must go to the higher way. Uses a set nothing touched yet.
  task automatic test_lru_tie_break();
    wait_drain();
    write_regs(6'd2, 6'd4, 6'd2);
    send_access(sacl_pkg::REQ_LOAD,  addr_of(64'd1, 2, 64'd0));
    send_access(sacl_pkg::REQ_STORE, addr_of(64'd2, 2, 64'd5));
    wait_drain();
    write_regs(6'd2, 6'd4, 6'd1);
    send_access(sacl_pkg::REQ_LOAD,  addr_of(64'd1, 2, 64'd3));
    wait_drain();
    write_regs(6'd2, 6'd4, 6'd2);
    send_access(sacl_pkg::REQ_LOAD,   addr_of(64'd3, 2, 64'd0));
    send_access(sacl_pkg::REQ_MODIFY, addr_of(64'd1, 2, 64'd0));
    send_access(sacl_pkg::REQ_LOAD,   addr_of(64'd2, 2, 64'd0));
  endtask

  // Register values below and above range are clamped on use.
  task automatic test_register_clamping();
    wait_drain();
    write_regs(6'd0, 6'd0, 6'd0);
    send_access(sacl_pkg::REQ_LOAD, 64'h5555_5555_5555_5555);
    send_access(REQ_SPARE,          64'h5555_5555_5555_5554);
    wait_drain();
    write_regs(6'h3F, 6'h3F, 6'h3F);
    send_access(sacl_pkg::REQ_STORE,  64'hFFFF_FFFF_FFFF_FFFF);
    send_access(sacl_pkg::REQ_LOAD,   64'hFFFF_0000_0000_0000);
    send_access(sacl_pkg::REQ_MODIFY, 64'hFF00_0000_0000_0000);
  endtask

  // Random accesses under a series of settings, extremes included; contents
  // carry over from one setting to the next.
  task automatic test_random_sweep();
    for (int p = 0; p < 9; p++) begin
      wait_drain();
      case (p)
        0: write_regs(6'd8, 6'd48, 6'd8);
        1: write_regs(6'd1, 6'd1, 6'd8);
        2: write_regs(6'd3, 6'd5, 6'd4);
        3: write_regs(6'd1, 6'd48, 6'd1);
        4: write_regs(6'd5, 6'd20, 6'd6);
        5: write_regs(6'd8, 6'd1, 6'd2);
        6: write_regs(6'd2, 6'd12, 6'd3);
        7: write_regs(6'd7, 6'd33, 6'd7);
        default: write_regs(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                            6'($urandom_range(0, 63)));
      endcase
      repeat (150) send_random_access();
    end
  endtask

  // Hold results off long enough that the block backs up into its input while
  // the sender keeps offering, then let the sender pause until all is drained.
  task automatic test_backpressure();
    wait_drain();
    write_regs(6'd2, 6'd6, 6'd4);
    tx_gaps_on = 1'b0;
    rx_hold_cycles = 300;
    repeat (40) send_random_access();
    wait_drain();
    repeat (20) send_random_access();
    tx_gaps_on = 1'b1;
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_streaming_tail();
    wait_drain();
    write_regs(6'd4, 6'd6, 6'd8);
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    repeat (150) send_random_access();
  endtask

  initial begin : stimulus
    rst       = 1'b1;
    cfg_write = 1'b0;
    cfg_index = sacl_pkg::CFG_SET_BITS;
    cfg_data  = '0;
    in_valid  = 1'b0;
    req_type  = sacl_pkg::REQ_LOAD;
    address   = '0;
    for (int i = 0; i < LINE_COUNT; i++) begin
      cached_valid[i] = 1'b0;
      cached_tag[i]   = '0;
      cached_age[i]   = '0;
    end

    // Reset is held once, at the start; the block then runs its clearing pass
    // with in_stall high, which send_access simply waits out.
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_lru_tie_break();
    test_register_clamping();
    test_random_sweep();
    test_backpressure();
    test_streaming_tail();

    // Drain, then wait for any stray result to show up.
    wait_drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
